// File: src/dtrm_pkg.sv
`default_nettype none
package dtrm_pkg;

  // configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_GRID_COLS     = 2'd0;
  localparam cfg_idx_t REG_GRID_ROWS     = 2'd1;
  localparam cfg_idx_t REG_SCREEN_WIDTH  = 2'd2;
  localparam cfg_idx_t REG_SCREEN_HEIGHT = 2'd3;

  // field widths
  localparam int GRID_CFG_W = 9;
  localparam int PIX_CFG_W  = 13;
  localparam int CFG_DATA_W = 13;
  localparam int POS_W      = 12;
  localparam int RW_W       = 13;
  localparam int RH_W       = 5;
  localparam int NUM_W      = 16;

  // saturation value of the run width
  localparam logic [RW_W-1:0] W_MAX = {RW_W{1'b1}};

  // reset values of the registers
  localparam logic [GRID_CFG_W-1:0] GRID_COLS_RST     = 9'd20;
  localparam logic [GRID_CFG_W-1:0] GRID_ROWS_RST     = 9'd15;
  localparam logic [PIX_CFG_W-1:0]  SCREEN_WIDTH_RST  = 13'd320;
  localparam logic [PIX_CFG_W-1:0]  SCREEN_HEIGHT_RST = 13'd240;

  // rectangle queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [GRID_CFG_W-1:0] grid_cols;
    logic [GRID_CFG_W-1:0] grid_rows;
    logic [PIX_CFG_W-1:0]  screen_width;
    logic [PIX_CFG_W-1:0]  screen_height;
  } cfg_t;

  // closed run waiting for its number; first marks the first one of a frame
  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [RW_W-1:0]  w;
    logic [RH_W-1:0]  h;
    logic             first;
  } rect_entry_t;

  // queue status seen by front and back
  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage
`default_nettype wire

// File: src/dtrm_front.sv
`default_nettype none
module dtrm_front #(
  parameter int TILE_SHIFT = 4,
  parameter int MAX_GRID   = 256
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  dtrm_pkg::cfg_t         cfg,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire                    in_tile_dirty,
  input  dtrm_pkg::q_stat_t      q_stat,
  output logic                   push,
  output dtrm_pkg::rect_entry_t  push_entry
);
  import dtrm_pkg::*;

  localparam int IDX_W  = $clog2(MAX_GRID);
  localparam int EW_MIN = $clog2(MAX_GRID + 1);
  localparam int EW     = (EW_MIN > GRID_CFG_W) ? EW_MIN : GRID_CFG_W;
  localparam int PW     = IDX_W + TILE_SHIFT;
  localparam int CW     = (PW > PIX_CFG_W) ? PW : PIX_CFG_W;
  localparam int TS_W   = TILE_SHIFT + 1;
  localparam int TILE   = 1 << TILE_SHIFT;

  logic [IDX_W-1:0] tile_col_r, tile_col_nxt;
  logic [IDX_W-1:0] tile_row_r, tile_row_nxt;
  logic [IDX_W-1:0] run_start_r, run_start_nxt;
  logic [RW_W-1:0]  run_width_r, run_width_nxt;
  logic             first_r, first_nxt;

  logic [EW-1:0]    cols, rows;
  logic             accept, last_col, last_row, close;
  logic [TS_W-1:0]  tw, th;
  logic [RW_W:0]    width_sum;
  logic [RW_W-1:0]  width_cur;
  logic [IDX_W-1:0] start_cur;
  logic [CW-1:0]    x_pix, y_pix;

  // grid size with zero read as one and large values held at the maximum
  function automatic logic [EW-1:0] eff_grid(input logic [GRID_CFG_W-1:0] v);
    logic [EW-1:0] ve;
    ve = EW'(v);
    if (ve == '0) begin
      return EW'(1);
    end else if (ve > EW'(MAX_GRID)) begin
      return EW'(MAX_GRID);
    end
    return ve;
  endfunction

  // tile size clipped against the screen edge
  function automatic logic [TS_W-1:0] clip_size(input logic [IDX_W-1:0] idx,
                                                input logic [PIX_CFG_W-1:0] limit);
    logic [CW-1:0] start;
    logic [CW-1:0] rest;
    start = CW'(idx) << TILE_SHIFT;
    rest  = CW'(limit) - start;
    if (start >= CW'(limit)) begin
      return '0;
    end else if (rest < CW'(TILE)) begin
      return TS_W'(rest);
    end
    return TS_W'(TILE);
  endfunction

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  // position and clipping of the current tile
  always_comb begin
    cols     = eff_grid(cfg.grid_cols);
    rows     = eff_grid(cfg.grid_rows);
    last_col = (EW'(tile_col_r) + EW'(1)) >= cols;
    last_row = (EW'(tile_row_r) + EW'(1)) >= rows;
    tw       = clip_size(tile_col_r, cfg.screen_width);
    th       = clip_size(tile_row_r, cfg.screen_height);
  end

  // run extension and closing
  always_comb begin
    width_sum = {1'b0, run_width_r} + (RW_W + 1)'(tw);
    start_cur = run_start_r;
    width_cur = run_width_r;
    if (in_tile_dirty) begin
      if (run_width_r == '0) begin
        start_cur = tile_col_r;
      end
      width_cur = width_sum[RW_W] ? W_MAX : width_sum[RW_W-1:0];
    end
    close = (last_col || !in_tile_dirty) && (width_cur != '0);
  end

  // rectangle for the queue
  always_comb begin
    x_pix            = CW'(start_cur) << TILE_SHIFT;
    y_pix            = CW'(tile_row_r) << TILE_SHIFT;
    push             = accept && close && (th != '0);
    push_entry.x     = x_pix[POS_W-1:0];
    push_entry.y     = y_pix[POS_W-1:0];
    push_entry.w     = width_cur;
    push_entry.h     = RH_W'(th);
    push_entry.first = first_r;
  end

  // next state on an accepted tile
  always_comb begin
    tile_col_nxt  = tile_col_r;
    tile_row_nxt  = tile_row_r;
    run_start_nxt = run_start_r;
    run_width_nxt = run_width_r;
    first_nxt     = first_r;
    if (accept) begin
      run_start_nxt = start_cur;
      run_width_nxt = close ? '0 : width_cur;
      if (push) begin
        first_nxt = 1'b0;
      end
      if (last_col) begin
        tile_col_nxt = '0;
        if (last_row) begin
          tile_row_nxt = '0;
          first_nxt    = 1'b1;
        end else begin
          tile_row_nxt = tile_row_r + IDX_W'(1);
        end
      end else begin
        tile_col_nxt = tile_col_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_col_r  <= '0;
      tile_row_r  <= '0;
      run_start_r <= '0;
      run_width_r <= '0;
      first_r     <= 1'b0;
    end else begin
      tile_col_r  <= tile_col_nxt;
      tile_row_r  <= tile_row_nxt;
      run_start_r <= run_start_nxt;
      run_width_r <= run_width_nxt;
      first_r     <= first_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/dtrm_queue.sv
`default_nettype none
module dtrm_queue (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push,
  input  dtrm_pkg::rect_entry_t  push_entry,
  input  wire                    pop,
  output dtrm_pkg::rect_entry_t  head_entry,
  output dtrm_pkg::q_stat_t      q_stat
);
  import dtrm_pkg::*;

  rect_entry_t        mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  // status and head
  assign q_stat.valid = (count_r != '0);
  assign q_stat.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign head_entry   = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

// File: src/dtrm_back.sv
`default_nettype none
module dtrm_back (
  input  wire                                clk,
  input  wire                                rst_n,
  input  dtrm_pkg::q_stat_t                  q_stat,
  input  dtrm_pkg::rect_entry_t              head_entry,
  output logic                               pop,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [dtrm_pkg::POS_W-1:0]         out_rect_x,
  output logic [dtrm_pkg::POS_W-1:0]         out_rect_y,
  output logic [dtrm_pkg::RW_W-1:0]          out_rect_w,
  output logic [dtrm_pkg::RH_W-1:0]          out_rect_h,
  output logic [dtrm_pkg::NUM_W-1:0]         out_rect_number
);
  import dtrm_pkg::*;

  logic             out_valid_r, out_valid_nxt;
  logic [NUM_W-1:0] count_r, count_nxt;
  logic [NUM_W-1:0] number;
  rect_entry_t      rect_r;
  logic [NUM_W-1:0] number_r;

  // load the output register when it is empty or being taken
  assign pop = q_stat.valid && (!out_valid_r || out_ready);

  // numbering restarts at the first rectangle of a frame
  always_comb begin
    number        = head_entry.first ? '0 : count_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    if (pop) begin
      count_nxt     = number + NUM_W'(1);
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      rect_r   <= head_entry;
      number_r <= number;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rect_x      = rect_r.x;
  assign out_rect_y      = rect_r.y;
  assign out_rect_w      = rect_r.w;
  assign out_rect_h      = rect_r.h;
  assign out_rect_number = number_r;

endmodule
`default_nettype wire

// File: src/dirty_tile_rect_merger_unit.sv
// Dirty tile rectangle merger.
// Input channel (in_valid/in_ready, in_tile_dirty): one dirty bit per tile in
// raster order over grid_cols by grid_rows tiles. One tile is taken each cycle while the queue is not full.
// Output channel (out_valid/out_ready, out_rect_*): one transaction per closed
// run of dirty tiles in a tile row, with pixel position, clipped width and
// height, and the rectangle's number within the frame.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): registers
// 0 grid_cols, 1 grid_rows, 2 screen_width, 3 screen_height; cfg_ready is
// always high. Write only while the block is idle.
// A rectangle closed by an accepted tile is written into the queue and then
// loaded into the output register that drives out_valid. Throughput: one tile per
// cycle while the queue is not full, from the run update in the front stage.
// A 4-entry rectangle queue and the output register absorb receiver stalls;
// when the queue is full in_ready drops until the receiver takes a transaction.
// Reset: position, open run and rectangle count clear to zero, the queue empties,
// and the registers return to a 20 by 15 grid on a 320 by 240 screen.
`default_nettype none
module dirty_tile_rect_merger_unit #(
  parameter int TILE_SHIFT = 4,
  parameter int MAX_GRID   = 256
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire                                in_tile_dirty,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [dtrm_pkg::POS_W-1:0]         out_rect_x,
  output logic [dtrm_pkg::POS_W-1:0]         out_rect_y,
  output logic [dtrm_pkg::RW_W-1:0]          out_rect_w,
  output logic [dtrm_pkg::RH_W-1:0]          out_rect_h,
  output logic [dtrm_pkg::NUM_W-1:0]         out_rect_number,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  dtrm_pkg::cfg_idx_t                 cfg_index,
  input  wire [dtrm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dtrm_pkg::*;

  cfg_t        cfg_r, cfg_nxt;
  q_stat_t     q_stat;
  rect_entry_t push_entry;
  rect_entry_t head_entry;
  logic        push;
  logic        pop;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRID_COLS:     cfg_nxt.grid_cols     = cfg_data[GRID_CFG_W-1:0];
        REG_GRID_ROWS:     cfg_nxt.grid_rows     = cfg_data[GRID_CFG_W-1:0];
        REG_SCREEN_WIDTH:  cfg_nxt.screen_width  = cfg_data[PIX_CFG_W-1:0];
        REG_SCREEN_HEIGHT: cfg_nxt.screen_height = cfg_data[PIX_CFG_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_cols     <= GRID_COLS_RST;
      cfg_r.grid_rows     <= GRID_ROWS_RST;
      cfg_r.screen_width  <= SCREEN_WIDTH_RST;
      cfg_r.screen_height <= SCREEN_HEIGHT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // tile scan and run merging
  dtrm_front #(
    .TILE_SHIFT (TILE_SHIFT),
    .MAX_GRID   (MAX_GRID)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_tile_dirty (in_tile_dirty),
    .q_stat        (q_stat),
    .push          (push),
    .push_entry    (push_entry)
  );

  // closed rectangles waiting for output
  dtrm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .q_stat     (q_stat)
  );

  // numbering and output register
  dtrm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .head_entry      (head_entry),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_rect_x      (out_rect_x),
    .out_rect_y      (out_rect_y),
    .out_rect_w      (out_rect_w),
    .out_rect_h      (out_rect_h),
    .out_rect_number (out_rect_number)
  );

  // no rectangle right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // every delivered rectangle has a size
  a_rect_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rect_w != '0) && (out_rect_h != '0))
    else $error("empty rectangle delivered");

  // numbers run on by one or restart at a new frame
  a_rect_number: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) ##1 out_valid |->
      (out_rect_number == NUM_W'($past(out_rect_number) + NUM_W'(1))) ||
      (out_rect_number == '0))
    else $error("rectangle number out of sequence");

  // a taken result with an empty queue leaves the output idle
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !q_stat.valid) |=> !out_valid)
    else $error("output valid without a queued rectangle");

endmodule
`default_nettype wire
